/* design/m65_pkg.sv */
// shared types and constants for the 6502 subset core
package m65_pkg;

    localparam logic [15:0] RESET_START = 16'hFFFC;
    localparam logic [7:0]  RESET_STATUS = 8'h34;
    localparam logic [7:0]  FLAG_C = 8'h01;
    localparam logic [7:0]  FLAG_Z = 8'h02;
    localparam logic [7:0]  FLAG_V = 8'h40;
    localparam logic [7:0]  FLAG_N = 8'h80;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [3:0] {
        AM_NONE, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
        AM_INDX, AM_INDY
    } amode_t;

    typedef enum logic [4:0] {
        K_BAD, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_TAX, K_TXA, K_TAY,
        K_TYA, K_INC, K_DEC, K_INX, K_DEX, K_INY, K_DEY, K_AND, K_ORA, K_EOR,
        K_BIT, K_ASL, K_LSR, K_ROL, K_ROR, K_NOP
    } kind_t;

    // memory address source selected by the controller
    typedef enum logic [2:0] {
        AS_PC, AS_PTR_LO, AS_PTR_HI, AS_EA, AS_EXT
    } asel_t;

    // commands from controller to datapath
    typedef struct packed {
        asel_t      asel;
        logic       mem_we;      // write wdata to selected address
        logic       wr_ext;      // write data is the input byte
        logic       pc_inc;      // advance pc
        logic       ld_op;       // latch read data as opcode
        logic       ld_lo;       // latch read data as low operand
        logic       ld_hi;       // latch read data as high operand
        logic       ld_ptr_lo;   // latch pointer low byte
        logic       mk_ea;       // form effective address from operands
        logic       mk_ea_ind;   // form effective address from pointer bytes
        logic       imm_ea;      // effective address is current pc
        logic       exec;        // apply operation using read data
        logic       ld_rb;       // capture read byte
        logic       clr_out;     // clear read byte and unsupported
        logic       set_bad;     // flag unsupported
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        kind_t  kind;
        amode_t am;
    } stat_t;

    // opcode decode
    function automatic stat_t decode(input logic [7:0] op);
        stat_t s;
        logic [2:0] aaa;
        logic [2:0] bbb;
        aaa = op[7:5];
        bbb = op[4:2];
        s.am = AM_NONE;
        s.kind = K_BAD;
        unique case (op)
            8'hA9: begin s.kind = K_LDA; s.am = AM_IMM; end
            8'hA5: begin s.kind = K_LDA; s.am = AM_ZP; end
            8'hB5: begin s.kind = K_LDA; s.am = AM_ZPX; end
            8'hAD: begin s.kind = K_LDA; s.am = AM_ABS; end
            8'hBD: begin s.kind = K_LDA; s.am = AM_ABSX; end
            8'hB9: begin s.kind = K_LDA; s.am = AM_ABSY; end
            8'hA1: begin s.kind = K_LDA; s.am = AM_INDX; end
            8'hB1: begin s.kind = K_LDA; s.am = AM_INDY; end
            8'hA2: begin s.kind = K_LDX; s.am = AM_IMM; end
            8'hA6: begin s.kind = K_LDX; s.am = AM_ZP; end
            8'hB6: begin s.kind = K_LDX; s.am = AM_ZPY; end
            8'hAE: begin s.kind = K_LDX; s.am = AM_ABS; end
            8'hBE: begin s.kind = K_LDX; s.am = AM_ABSY; end
            8'hA0: begin s.kind = K_LDY; s.am = AM_IMM; end
            8'hA4: begin s.kind = K_LDY; s.am = AM_ZP; end
            8'hB4: begin s.kind = K_LDY; s.am = AM_ZPX; end
            8'hAC: begin s.kind = K_LDY; s.am = AM_ABS; end
            8'hBC: begin s.kind = K_LDY; s.am = AM_ABSX; end
            8'h85: begin s.kind = K_STA; s.am = AM_ZP; end
            8'h95: begin s.kind = K_STA; s.am = AM_ZPX; end
            8'h8D: begin s.kind = K_STA; s.am = AM_ABS; end
            8'h9D: begin s.kind = K_STA; s.am = AM_ABSX; end
            8'h99: begin s.kind = K_STA; s.am = AM_ABSY; end
            8'h81: begin s.kind = K_STA; s.am = AM_INDX; end
            8'h91: begin s.kind = K_STA; s.am = AM_INDY; end
            8'h86: begin s.kind = K_STX; s.am = AM_ZP; end
            8'h96: begin s.kind = K_STX; s.am = AM_ZPY; end
            8'h8E: begin s.kind = K_STX; s.am = AM_ABS; end
            8'h84: begin s.kind = K_STY; s.am = AM_ZP; end
            8'h94: begin s.kind = K_STY; s.am = AM_ZPX; end
            8'h8C: begin s.kind = K_STY; s.am = AM_ABS; end
            8'hAA: s.kind = K_TAX;
            8'h8A: s.kind = K_TXA;
            8'hA8: s.kind = K_TAY;
            8'h98: s.kind = K_TYA;
            8'hE6: begin s.kind = K_INC; s.am = AM_ZP; end
            8'hF6: begin s.kind = K_INC; s.am = AM_ZPX; end
            8'hEE: begin s.kind = K_INC; s.am = AM_ABS; end
            8'hFE: begin s.kind = K_INC; s.am = AM_ABSX; end
            8'hC6: begin s.kind = K_DEC; s.am = AM_ZP; end
            8'hD6: begin s.kind = K_DEC; s.am = AM_ZPX; end
            8'hCE: begin s.kind = K_DEC; s.am = AM_ABS; end
            8'hDE: begin s.kind = K_DEC; s.am = AM_ABSX; end
            8'hE8: s.kind = K_INX;
            8'hCA: s.kind = K_DEX;
            8'hC8: s.kind = K_INY;
            8'h88: s.kind = K_DEY;
            8'h24: begin s.kind = K_BIT; s.am = AM_ZP; end
            8'h2C: begin s.kind = K_BIT; s.am = AM_ABS; end
            8'hEA: s.kind = K_NOP;
            default:
            begin
                // regular groups: logic ops and shifts
                if (op[1:0] == 2'b01 && aaa <= 3'd2) begin
                    unique case (aaa)
                        3'd0:    s.kind = K_ORA;
                        3'd1:    s.kind = K_AND;
                        default: s.kind = K_EOR;
                    endcase
                    unique case (bbb)
                        3'd0:    s.am = AM_INDX;
                        3'd1:    s.am = AM_ZP;
                        3'd2:    s.am = AM_IMM;
                        3'd3:    s.am = AM_ABS;
                        3'd4:    s.am = AM_INDY;
                        3'd5:    s.am = AM_ZPX;
                        3'd6:    s.am = AM_ABSY;
                        default: s.am = AM_ABSX;
                    endcase
                end else if (op[1:0] == 2'b10 && aaa <= 3'd3 && bbb != 3'd0
                             && bbb != 3'd4 && bbb != 3'd6) begin
                    unique case (aaa[1:0])
                        2'd0:    s.kind = K_ASL;
                        2'd1:    s.kind = K_ROL;
                        2'd2:    s.kind = K_LSR;
                        default: s.kind = K_ROR;
                    endcase
                    unique case (bbb)
                        3'd1:    s.am = AM_ZP;
                        3'd3:    s.am = AM_ABS;
                        3'd5:    s.am = AM_ZPX;
                        3'd7:    s.am = AM_ABSX;
                        default: s.am = AM_NONE;
                    endcase
                end
            end
        endcase
        return s;
    endfunction

endpackage

/* design/m65_if.sv */
// valid/ready channel interfaces for input and result beats
interface m65_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    modport source (output valid, mode, mem_address, mem_data, input ready);
    modport sink (input valid, mode, mem_address, mem_data, output ready);
endinterface

interface m65_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  flags_out;
    logic [15:0] pc_out;
    logic [7:0]  read_byte;
    logic        unsupported;
    modport source (output valid, acc_out, x_out, y_out, flags_out, pc_out,
                    read_byte, unsupported, input ready);
    modport sink (input valid, acc_out, x_out, y_out, flags_out, pc_out,
                  read_byte, unsupported, output ready);
endinterface

/* design/m65_datapath.sv */
// registers, byte memory, address forming and alu of the core
module m65_datapath #(
    parameter int ADDR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  m65_pkg::cmd_t     cmd,
    input  logic              pc_load,
    input  logic [15:0]       pc_value,
    input  logic [15:0]       ext_address,
    input  logic [7:0]        ext_data,
    output m65_pkg::stat_t    stat,
    output logic [7:0]        acc,
    output logic [7:0]        xr,
    output logic [7:0]        yr,
    output logic [7:0]        flags,
    output logic [15:0]       pc,
    output logic [7:0]        read_byte,
    output logic              unsupported
);
    import m65_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;
    logic [7:0]  acc_reg, x_reg, y_reg, p_reg;
    logic [15:0] pc_reg;
    logic [7:0]  op_reg, lo_reg, hi_reg, ptr_reg;
    logic [15:0] ea_reg;
    logic [7:0]  rb_reg;
    logic        bad_reg;
    stat_t       dec;

    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  res;
    logic [7:0]  p_next;
    logic        res_to_mem;
    logic [7:0]  acc_next, x_next, y_next;

    assign dec = decode(op_reg);
    assign stat = dec;

    // memory address select
    always_comb
    begin
        unique case (cmd.asel)
            AS_PC:     addr = pc_reg;
            AS_PTR_LO: addr = {8'h00, ptr_reg};
            AS_PTR_HI: addr = {8'h00, ptr_reg + 8'd1};
            AS_EA:     addr = ea_reg;
            default:   addr = ext_address;
        endcase
    end

    // operation on the fetched operand
    always_comb
    begin
        logic c;
        c = p_reg[0];
        res = 8'h00;
        res_to_mem = 1'b0;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        unique case (dec.kind)
            K_LDA: begin acc_next = rdata_reg; res = rdata_reg; end
            K_LDX: begin x_next = rdata_reg; res = rdata_reg; end
            K_LDY: begin y_next = rdata_reg; res = rdata_reg; end
            K_STA: begin res = acc_reg; res_to_mem = 1'b1; end
            K_STX: begin res = x_reg; res_to_mem = 1'b1; end
            K_STY: begin res = y_reg; res_to_mem = 1'b1; end
            K_TAX: begin x_next = acc_reg; res = acc_reg; end
            K_TXA: begin acc_next = x_reg; res = x_reg; end
            K_TAY: begin y_next = acc_reg; res = acc_reg; end
            K_TYA: begin acc_next = y_reg; res = y_reg; end
            K_INC: begin res = rdata_reg + 8'd1; res_to_mem = 1'b1; end
            K_DEC: begin res = rdata_reg - 8'd1; res_to_mem = 1'b1; end
            K_INX: begin res = x_reg + 8'd1; x_next = res; end
            K_DEX: begin res = x_reg - 8'd1; x_next = res; end
            K_INY: begin res = y_reg + 8'd1; y_next = res; end
            K_DEY: begin res = y_reg - 8'd1; y_next = res; end
            K_AND: begin res = acc_reg & rdata_reg; acc_next = res; end
            K_ORA: begin res = acc_reg | rdata_reg; acc_next = res; end
            K_EOR: begin res = acc_reg ^ rdata_reg; acc_next = res; end
            K_ASL, K_LSR, K_ROL, K_ROR:
            begin
                logic [7:0] v;
                v = (dec.am == AM_NONE) ? acc_reg : rdata_reg;
                unique case (dec.kind)
                    K_ASL:   begin p_next[0] = v[7]; res = {v[6:0], 1'b0}; end
                    K_ROL:   begin p_next[0] = v[7]; res = {v[6:0], c}; end
                    K_LSR:   begin p_next[0] = v[0]; res = {1'b0, v[7:1]}; end
                    default: begin p_next[0] = v[0]; res = {c, v[7:1]}; end
                endcase
                if (dec.am == AM_NONE) acc_next = res;
                else res_to_mem = 1'b1;
            end
            default: ;
        endcase
        // flag update
        if (dec.kind == K_BIT) begin
            p_next[7] = rdata_reg[7];
            p_next[6] = rdata_reg[6];
            p_next[1] = ((acc_reg & rdata_reg) == 8'h00);
        end else if (dec.kind != K_STA && dec.kind != K_STX && dec.kind != K_STY
                     && dec.kind != K_NOP && dec.kind != K_BAD) begin
            p_next[7] = res[7];
            p_next[1] = (res == 8'h00);
        end
    end

    assign wdata = cmd.wr_ext ? ext_data : res;

    // byte memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we && (cmd.wr_ext || res_to_mem))
            mem[addr[ADDR_BITS-1:0]] <= wdata;
        rdata_reg <= mem[addr[ADDR_BITS-1:0]];
    end

    // architectural, opcode and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= 8'h00;
            x_reg <= 8'h00;
            y_reg <= 8'h00;
            p_reg <= RESET_STATUS;
            pc_reg <= RESET_START;
            rb_reg <= 8'h00;
            bad_reg <= 1'b0;
            op_reg <= 8'hEA;
        end else begin
            if (pc_load) pc_reg <= pc_value;
            else if (cmd.pc_inc) pc_reg <= pc_reg + 16'd1;
            if (cmd.ld_op) op_reg <= rdata_reg;
            if (cmd.clr_out) begin
                rb_reg <= 8'h00;
                bad_reg <= 1'b0;
            end
            if (cmd.ld_rb) rb_reg <= rdata_reg;
            if (cmd.set_bad) bad_reg <= 1'b1;
            if (cmd.exec) begin
                acc_reg <= acc_next;
                x_reg <= x_next;
                y_reg <= y_next;
                p_reg <= p_next;
            end
        end
    end

    // operand and address registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_lo) lo_reg <= rdata_reg;
        if (cmd.ld_hi) hi_reg <= rdata_reg;
        if (cmd.ld_ptr_lo) lo_reg <= rdata_reg;
        if (cmd.imm_ea) ea_reg <= pc_reg;
        if (cmd.mk_ea) begin
            unique case (dec.am)
                AM_ZP:   ea_reg <= {8'h00, lo_reg};
                AM_ZPX:  ea_reg <= {8'h00, lo_reg + x_reg};
                AM_ZPY:  ea_reg <= {8'h00, lo_reg + y_reg};
                AM_ABSX: ea_reg <= {hi_reg, lo_reg} + {8'h00, x_reg};
                AM_ABSY: ea_reg <= {hi_reg, lo_reg} + {8'h00, y_reg};
                default: ea_reg <= {hi_reg, lo_reg};
            endcase
            // pointer for indirect forms
            ptr_reg <= (dec.am == AM_INDX) ? lo_reg + x_reg : lo_reg;
        end
        if (cmd.mk_ea_ind) begin
            if (dec.am == AM_INDY) ea_reg <= {rdata_reg, lo_reg} + {8'h00, y_reg};
            else ea_reg <= {rdata_reg, lo_reg};
        end
    end

    assign acc = acc_reg;
    assign xr = x_reg;
    assign yr = y_reg;
    assign flags = p_reg;
    assign pc = pc_reg;
    assign read_byte = rb_reg;
    assign unsupported = bad_reg;

endmodule

/* design/m65_ctrl.sv */
// sequencer that steps one beat at a time: memory write, memory read, or fetch, address and execute
module m65_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  m65_pkg::stat_t    stat,
    output m65_pkg::cmd_t     cmd
);
    import m65_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_OPWAIT, S_DECODE, S_OPLO, S_OPHI, S_ADDR,
        S_PTRLO, S_PTRHI, S_INDEA, S_EAREAD, S_EXEC, S_DONE
    } state_t;

    state_t state_reg;
    logic   hi_needed;

    assign hi_needed = (stat.am == AM_ABS || stat.am == AM_ABSX
                        || stat.am == AM_ABSY);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    // per-state datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.asel = AS_PC;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.clr_out = in_valid;
                if (in_mode == MODE_EXEC) cmd.pc_inc = in_valid;
                else begin
                    cmd.asel = AS_EXT;
                    cmd.wr_ext = 1'b1;
                    cmd.mem_we = in_valid && (in_mode == MODE_WRITE);
                end
            end
            S_RDWAIT: cmd.ld_rb = 1'b1;
            S_OPWAIT: cmd.ld_op = 1'b1;
            S_DECODE:
            begin
                if (stat.kind == K_BAD) cmd.set_bad = 1'b1;
                else if (stat.am == AM_IMM) begin
                    cmd.imm_ea = 1'b1;
                    cmd.pc_inc = 1'b1;
                end else if (stat.am != AM_NONE) cmd.pc_inc = 1'b1;
            end
            S_OPLO:
            begin
                cmd.ld_lo = 1'b1;
                cmd.pc_inc = hi_needed;
            end
            S_OPHI:   cmd.ld_hi = 1'b1;
            S_ADDR:   cmd.mk_ea = 1'b1;
            S_PTRLO:  cmd.asel = AS_PTR_LO;
            S_PTRHI:
            begin
                cmd.asel = AS_PTR_HI;
                cmd.ld_ptr_lo = 1'b1;
            end
            S_INDEA:  cmd.mk_ea_ind = 1'b1;
            // operand read at the effective address
            S_EAREAD: cmd.asel = AS_EA;
            S_EXEC:
            begin
                cmd.asel = AS_EA;
                cmd.exec = 1'b1;
                cmd.mem_we = 1'b1;
            end
            S_DONE:   cmd.asel = AS_EA;
            default:  ;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid) begin
                        priority if (in_mode == MODE_EXEC) state_reg <= S_OPWAIT;
                        else if (in_mode == MODE_READ) state_reg <= S_RDWAIT;
                        else state_reg <= S_DONE;
                    end
                S_RDWAIT: state_reg <= S_DONE;
                S_OPWAIT: state_reg <= S_DECODE;
                S_DECODE:
                    priority if (stat.kind == K_BAD) state_reg <= S_DONE;
                    else if (stat.am == AM_NONE) state_reg <= S_EXEC;
                    else if (stat.am == AM_IMM) state_reg <= S_EAREAD;
                    else state_reg <= S_OPLO;
                S_OPLO:   state_reg <= hi_needed ? S_OPHI : S_ADDR;
                S_OPHI:   state_reg <= S_ADDR;
                S_ADDR:
                    if (stat.am == AM_INDX || stat.am == AM_INDY)
                        state_reg <= S_PTRLO;
                    else state_reg <= S_EAREAD;
                S_PTRLO:  state_reg <= S_PTRHI;
                S_PTRHI:  state_reg <= S_INDEA;
                S_INDEA:  state_reg <= S_EAREAD;
                S_EAREAD: state_reg <= S_EXEC;
                S_EXEC:   state_reg <= S_DONE;
                S_DONE:   if (out_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result and input open together");
    a_exec_leads_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> out_valid)
        else $error("execute not followed by result");
    a_no_write_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd.exec)
        else $error("registers updated while result pending");
`endif

endmodule

/* design/mos6502_core_subset.sv */
// 6502 subset core: execute, memory write and memory read beats
// Each beat yields one result beat. A memory write stores the input byte
// and then offers the result; a memory read registers the byte first. An
// executed instruction steps through the single-port byte memory: opcode
// fetch, decode, operand and pointer fetches as its mode needs, a read at
// the effective address, then execute/write-back. Unsupported opcodes go
// from decode to the result; implied ops skip the fetches and the read.
// The result is held until taken; the next beat is accepted after that.
// Memory contents are undefined until written; there is no clearing pass.
module mos6502_core_subset #(
    parameter int ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    m65_in_if.sink      in_ch,
    m65_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import m65_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] start_reg;
    logic        cfg_we;

    // configuration register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) start_reg <= RESET_START;
        else if (cfg_we) start_reg <= pwdata[15:0];
    end
    assign prdata = (paddr == 3'd0) ? {16'h0000, start_reg} : 32'h0;

    m65_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.mode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    m65_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .pc_load     (cfg_we),
        .pc_value    (pwdata[15:0]),
        .ext_address (in_ch.mem_address),
        .ext_data    (in_ch.mem_data),
        .stat        (stat),
        .acc         (out_ch.acc_out),
        .xr          (out_ch.x_out),
        .yr          (out_ch.y_out),
        .flags       (out_ch.flags_out),
        .pc          (out_ch.pc_out),
        .read_byte   (out_ch.read_byte),
        .unsupported (out_ch.unsupported)
    );

endmodule
